>>> design/lprsd_pkg.sv
// ============================================================================
// lprsd_pkg : shared types and constants for the LED panel shift driver
// Holds the store size, the command and sequencer codes, the controller
// command bundle and the serpentine address remap.
// ============================================================================
package lprsd_pkg;

    // Number of stored pixel bits shifted out per frame
    localparam int PIXELS = 256;
    localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    // Panel geometry: 16x16 pixels, 64-pixel boards, 8-pixel groups
    localparam int MAP_W = 8;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_DATA = 3'd1,
        PH_CLKH = 3'd2,
        PH_CLKL = 3'd3,
        PH_LATH = 3'd4,
        PH_LATL = 3'd5
    } phase_t;

    // Controller to datapath commands, valid for one accepted transaction
    typedef struct packed {
        logic accept;
        logic wr_en;
        logic start_frame;
        logic load_data;
        logic clk_set;
        logic clk_clr;
        logic bit_adv;
        logic latch_set;
        logic latch_clr;
        logic done;
        logic rej;
        logic busy_after;
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_bit;
    } stat_t;

    localparam logic [5:0] GRP_BASE [8] = '{6'd0, 6'd16, 6'd15, 6'd31,
                                            6'd48, 6'd32, 6'd63, 6'd47};
    localparam logic       GRP_DOWN [8] = '{1'b0, 1'b0, 1'b1, 1'b1,
                                            1'b0, 1'b0, 1'b1, 1'b1};

    // Serpentine remap of (x, y) onto the board chain address
    function automatic logic [MAP_W-1:0] map_address(input logic [3:0] col,
                                                     input logic [3:0] row);
        logic [7:0] p;
        logic [2:0] grp;
        logic [2:0] k;
        logic [5:0] off;
        p   = {row, col};
        grp = p[5:3];
        k   = p[2:0];
        off = GRP_DOWN[grp] ? (GRP_BASE[grp] - {3'b000, k})
                            : (GRP_BASE[grp] + {3'b000, k});
        return {p[7:6], off};
    endfunction

endpackage

>>> design/lprsd_ctrl.sv
// ============================================================================
// lprsd_ctrl : frame sequencer state machine
// Steps data, clock-high, clock-low per bit, then latch-high and latch-low,
// and issues commands to the datapath for each accepted transaction.
// ============================================================================
module lprsd_ctrl
    import lprsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  cmd_t  cmd,
    input  stat_t stat,
    output ctrl_t ctrl
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   busy_now;

    assign busy_now = (phase_reg != PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (cmd)
                CMD_START:
                begin
                    if (!busy_now)
                    begin
                        phase_next = PH_DATA;
                    end
                end
                CMD_TICK:
                begin
                    case (phase_reg)
                        PH_DATA: phase_next = PH_CLKH;
                        PH_CLKH: phase_next = PH_CLKL;
                        PH_CLKL: phase_next = stat.last_bit ? PH_LATH : PH_DATA;
                        PH_LATH: phase_next = PH_LATL;
                        PH_LATL: phase_next = PH_IDLE;
                        default: phase_next = PH_IDLE;
                    endcase
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // Datapath commands
    always_comb
    begin
        ctrl            = '0;
        ctrl.accept     = accept;
        ctrl.busy_after = (phase_next != PH_IDLE);
        if (accept)
        begin
            case (cmd)
                CMD_WRITE:
                begin
                    ctrl.rej   = busy_now;
                    ctrl.wr_en = !busy_now;
                end
                CMD_START:
                begin
                    ctrl.rej         = busy_now;
                    ctrl.start_frame = !busy_now;
                    ctrl.latch_clr   = !busy_now;
                end
                CMD_TICK:
                begin
                    case (phase_reg)
                        PH_DATA: ctrl.load_data = 1'b1;
                        PH_CLKH: ctrl.clk_set   = 1'b1;
                        PH_CLKL:
                        begin
                            ctrl.clk_clr = 1'b1;
                            ctrl.bit_adv = 1'b1;
                        end
                        PH_LATH: ctrl.latch_set = 1'b1;
                        PH_LATL:
                        begin
                            ctrl.latch_clr = 1'b1;
                            ctrl.done      = 1'b1;
                        end
                        default: ctrl.done = 1'b0;
                    endcase
                end
                default: ctrl.rej = 1'b0;
            endcase
        end
    end

endmodule

>>> design/lprsd_dpath.sv
// ============================================================================
// lprsd_dpath : pixel store, bit counter, pin levels and result registers
// The store is a one-bit memory with per-entry valid bits cleared at reset;
// its read is registered and prefetched at the next bit position.
// ============================================================================
module lprsd_dpath
    import lprsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_t      ctrl,
    input  logic [3:0] col_x,
    input  logic [3:0] row_y,
    input  logic [7:0] pixel_value,
    input  logic       cfg_we,
    input  logic       cfg_data,
    output stat_t      stat,
    output logic       result_valid,
    output logic       shift_clock,
    output logic       serial_data,
    output logic       latch_pin,
    output logic       enable_pin,
    output logic       busy_res,
    output logic       frame_done,
    output logic       rejected
);

    logic              store_mem [PIXELS];
    logic [PIXELS-1:0] valid_reg;
    logic              rd_data_reg;
    logic              rd_valid_reg;

    logic [ADDR_W-1:0] bit_pos_reg;
    logic [ADDR_W-1:0] bit_pos_next;

    logic [MAP_W-1:0]  map_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_in_range;
    logic              wr_fire;

    logic clk_level_reg;
    logic data_level_reg;
    logic latch_level_reg;
    logic oe_n_reg;
    logic result_valid_reg;
    logic busy_res_reg;
    logic frame_done_reg;
    logic rejected_reg;

    assign map_addr    = map_address(col_x, row_y);
    assign wr_addr     = ADDR_W'(map_addr);
    assign wr_in_range = (32'(map_addr) < PIXELS);
    assign wr_fire     = ctrl.wr_en && wr_in_range;

    assign stat.last_bit = (32'(bit_pos_reg) == PIXELS - 1);

    always_comb
    begin
        bit_pos_next = bit_pos_reg;
        if (ctrl.start_frame || ctrl.done)
        begin
            bit_pos_next = '0;
        end
        else if (ctrl.bit_adv)
        begin
            bit_pos_next = ADDR_W'(bit_pos_reg + 1'b1);
        end
    end

    // Store write and prefetch read
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            store_mem[wr_addr] <= (pixel_value != 8'd0);
        end
        rd_data_reg <= store_mem[bit_pos_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_fire)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[bit_pos_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg      <= '0;
            clk_level_reg    <= 1'b0;
            data_level_reg   <= 1'b0;
            latch_level_reg  <= 1'b0;
            oe_n_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            bit_pos_reg      <= bit_pos_next;
            result_valid_reg <= ctrl.accept;
            if (cfg_we)
            begin
                oe_n_reg <= cfg_data;
            end
            if (ctrl.load_data)
            begin
                data_level_reg <= rd_data_reg && rd_valid_reg;
            end
            if (ctrl.clk_set)
            begin
                clk_level_reg <= 1'b1;
            end
            else if (ctrl.clk_clr)
            begin
                clk_level_reg <= 1'b0;
            end
            if (ctrl.latch_set)
            begin
                latch_level_reg <= 1'b1;
            end
            else if (ctrl.latch_clr)
            begin
                latch_level_reg <= 1'b0;
            end
        end
    end

    // Status flags of the result, held until the next transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_res_reg   <= 1'b0;
            frame_done_reg <= 1'b0;
            rejected_reg   <= 1'b0;
        end
        else if (ctrl.accept)
        begin
            busy_res_reg   <= ctrl.busy_after;
            frame_done_reg <= ctrl.done;
            rejected_reg   <= ctrl.rej;
        end
    end

    assign result_valid = result_valid_reg;
    assign shift_clock  = clk_level_reg;
    assign serial_data  = data_level_reg;
    assign latch_pin    = latch_level_reg;
    assign enable_pin   = oe_n_reg;
    assign busy_res     = busy_res_reg;
    assign frame_done   = frame_done_reg;
    assign rejected     = rejected_reg;

endmodule

>>> design/led_panel_remap_shift_driver_top.sv
// ============================================================================
// led_panel_remap_shift_driver_top : LED panel shift-register driver
// Stores pixel bits at serpentine-remapped addresses and steps the shift,
// clock and latch pins of a chain of 64-pixel boards one tick at a time.
// ============================================================================
//
//  channel   handshake                    payload
//  -------   ---------------------------  --------------------------------------
//  command   start / busy                 cmd, col_x, row_y, pixel_value
//  config    cfg_valid / cfg_ready        cfg_data (output_enable_n level)
//  result    result_valid (strobe)        shift_clock, serial_data, latch_pin,
//                                         enable_pin, busy_res, frame_done,
//                                         rejected
//
//  Cycles: one transaction per clock; each result is registered and shows in the
//  cycle after its transaction, for exactly one cycle. The rate rests on a sequencer
//  that steps once per transaction and on the registered pixel store read, which
//  is prefetched at the next bit position so a data tick never waits.
//  Reset: rst_n clears the sequencer, pin levels and store valid bits at once;
//  no clearing pass, the block takes commands right after reset.
//  Stalls: busy stays low and the receiver cannot stall results.
//
module led_panel_remap_shift_driver_top
    import lprsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] cmd,
    input  logic [3:0] col_x,
    input  logic [3:0] row_y,
    input  logic [7:0] pixel_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    output logic       result_valid,
    output logic       shift_clock,
    output logic       serial_data,
    output logic       latch_pin,
    output logic       enable_pin,
    output logic       busy_res,
    output logic       frame_done,
    output logic       rejected
);

    ctrl_t ctrl;
    stat_t stat;
    logic  accept;

    // Every command is taken in the cycle it arrives
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Sequencer: decide what each transaction does to the pins and store
    lprsd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd_t'(cmd)),
        .stat   (stat),
        .ctrl   (ctrl)
    );

    // Datapath: hold pixel bits, bit counter, pin levels and result flags
    lprsd_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .col_x        (col_x),
        .row_y        (row_y),
        .pixel_value  (pixel_value),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .result_valid (result_valid),
        .shift_clock  (shift_clock),
        .serial_data  (serial_data),
        .latch_pin    (latch_pin),
        .enable_pin   (enable_pin),
        .busy_res     (busy_res),
        .frame_done   (frame_done),
        .rejected     (rejected)
    );

    // A result strobe only follows an accepted transaction
    a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy))
        else $error("result strobe without a preceding transaction");

    // A finished frame leaves the sequencer idle with the latch released
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> (!busy_res && !latch_pin))
        else $error("frame end while still busy or latched");

    // Rejection only happens while a frame is in flight
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rejected |-> busy_res)
        else $error("rejection reported while idle");

    // Shift clock and latch are high only inside a frame, never together
    a_clock_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (shift_clock || latch_pin) |-> (busy_res && !(shift_clock && latch_pin)))
        else $error("shift clock or latch high outside a frame");

endmodule

>>> verif/led_panel_remap_shift_driver_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// led_panel_remap_shift_driver_top_test : self-checking bench for the panel driver
// Drives pixel writes, frame starts, ticks and unused commands with random
// gaps. A tracker mirrors the store and sequencer and compares every result
// strobe, pin by pin, against its own prediction.
// ============================================================================
module led_panel_remap_shift_driver_top_test
    import lprsd_pkg::*;
();

    // Command code that the block has no use for; it must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Pin levels and flags carried by one result strobe
    typedef struct packed {
        logic shift_clock;
        logic serial_data;
        logic latch_pin;
        logic enable_pin;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } pin_state_t;

    // ------------------------------------------------------------------------
    // Tracker: mirrors the pixel store and the shift sequencer, queues the
    // pin state each accepted command should produce and checks the strobes.
    // ------------------------------------------------------------------------
    class panel_pin_tracker;
        logic [PIXELS-1:0] lit;
        int                bit_pos;
        phase_t            phase;
        logic              clk_lvl;
        logic              data_lvl;
        logic              latch_lvl;
        logic              oe_n;
        pin_state_t        pending_pins[$];
        int                errors;
        int                n_cmds;
        int                n_checked;
        int                n_frames;
        int                n_rejects;
        int                n_cfg;

        function new();
            lit       = '0;
            bit_pos   = 0;
            phase     = PH_IDLE;
            clk_lvl   = 1'b0;
            data_lvl  = 1'b0;
            latch_lvl = 1'b0;
            oe_n      = 1'b0;
            errors    = 0;
            n_cmds    = 0;
            n_checked = 0;
            n_frames  = 0;
            n_rejects = 0;
            n_cfg     = 0;
        endfunction

        // Serpentine remap: within each 64-pixel board the eight 8-pixel
        // groups land in pairs, two forward and then two reversed.
        function int panel_addr(logic [3:0] x, logic [3:0] y);
            logic [7:0] p;
            logic [5:0] k;
            logic [5:0] off;
            p = {y, x};
            k = {3'b000, p[2:0]};
            case (p[5:3])
                3'd0:    off = k;
                3'd1:    off = 6'd16 + k;
                3'd2:    off = 6'd15 - k;
                3'd3:    off = 6'd31 - k;
                3'd4:    off = 6'd48 + k;
                3'd5:    off = 6'd32 + k;
                3'd6:    off = 6'd63 - k;
                default: off = 6'd47 - k;
            endcase
            return int'({p[7:6], off});
        endfunction

        function void set_enable(logic lvl);
            oe_n = lvl;
            n_cfg++;
        endfunction

        function bit frame_active();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return pending_pins.size();
        endfunction

        // Advance the mirror by one accepted command and queue its pin state
        function void note_command(logic [1:0] op, logic [3:0] x, logic [3:0] y,
                                   logic [7:0] v);
            pin_state_t r;
            logic       shifting;
            int         a;
            r        = '0;
            shifting = (phase != PH_IDLE);
            n_cmds++;
            case (op)
                CMD_WRITE:
                begin
                    if (shifting)
                        r.rejected = 1'b1;
                    else
                    begin
                        a = panel_addr(x, y);
                        if (a < PIXELS)
                            lit[a] = (v != 8'd0);
                    end
                end
                CMD_START:
                begin
                    if (shifting)
                        r.rejected = 1'b1;
                    else
                    begin
                        latch_lvl = 1'b0;
                        bit_pos   = 0;
                        phase     = PH_DATA;
                    end
                end
                CMD_TICK:
                begin
                    if (shifting)
                    begin
                        case (phase)
                            PH_DATA:
                            begin
                                data_lvl = (bit_pos < PIXELS) ? lit[bit_pos] : 1'b0;
                                phase    = PH_CLKH;
                            end
                            PH_CLKH:
                            begin
                                clk_lvl = 1'b1;
                                phase   = PH_CLKL;
                            end
                            PH_CLKL:
                            begin
                                clk_lvl = 1'b0;
                                bit_pos++;
                                if (bit_pos >= PIXELS)
                                    phase = PH_LATH;
                                else
                                    phase = PH_DATA;
                            end
                            PH_LATH:
                            begin
                                latch_lvl = 1'b1;
                                phase     = PH_LATL;
                            end
                            default:
                            begin
                                latch_lvl    = 1'b0;
                                bit_pos      = 0;
                                phase        = PH_IDLE;
                                r.frame_done = 1'b1;
                                n_frames++;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
            if (r.rejected)
                n_rejects++;
            r.shift_clock = clk_lvl;
            r.serial_data = data_lvl;
            r.latch_pin   = latch_lvl;
            r.enable_pin  = oe_n;
            r.busy_res    = (phase != PH_IDLE);
            pending_pins.push_back(r);
        endfunction

        function void mismatch(string name, logic want, logic got);
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
            errors++;
        endfunction

        // Compare one result strobe against the oldest queued pin state
        function void check_pins(pin_state_t got);
            pin_state_t want;
            if (pending_pins.size() == 0)
            begin
                $display("%0t: result with nothing queued, actual %b", $time, got);
                errors++;
                return;
            end
            want = pending_pins.pop_front();
            n_checked++;
            if (got.shift_clock !== want.shift_clock)
                mismatch("shift_clock", want.shift_clock, got.shift_clock);
            if (got.serial_data !== want.serial_data)
                mismatch("serial_data", want.serial_data, got.serial_data);
            if (got.latch_pin !== want.latch_pin)
                mismatch("latch_pin", want.latch_pin, got.latch_pin);
            if (got.enable_pin !== want.enable_pin)
                mismatch("enable_pin", want.enable_pin, got.enable_pin);
            if (got.busy_res !== want.busy_res)
                mismatch("busy_res", want.busy_res, got.busy_res);
            if (got.frame_done !== want.frame_done)
                mismatch("frame_done", want.frame_done, got.frame_done);
            if (got.rejected !== want.rejected)
                mismatch("rejected", want.rejected, got.rejected);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] cmd;
    logic [3:0] col_x;
    logic [3:0] row_y;
    logic [7:0] pixel_value;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       result_valid;
    logic       shift_clock;
    logic       serial_data;
    logic       latch_pin;
    logic       enable_pin;
    logic       busy_res;
    logic       frame_done;
    logic       rejected;

    led_panel_remap_shift_driver_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .col_x        (col_x),
        .row_y        (row_y),
        .pixel_value  (pixel_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .shift_clock  (shift_clock),
        .serial_data  (serial_data),
        .latch_pin    (latch_pin),
        .enable_pin   (enable_pin),
        .busy_res     (busy_res),
        .frame_done   (frame_done),
        .rejected     (rejected)
    );

    panel_pin_tracker pins = new();

    // Gap control: runs of back-to-back commands and runs of random gaps
    // are picked at random so idle cycles land on every sequencer phase.
    int run_left = 0;
    bit no_gaps  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: note each accepted command first, then check any strobe; a result
    // shows in the cycle after its own command, so its entry is already queued.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pins.note_command(cmd, col_x, row_y, pixel_value);
        if (rst_n && result_valid)
            pins.check_pins({shift_clock, serial_data, latch_pin, enable_pin,
                             busy_res, frame_done, rejected});
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Issue one command and hold it until the block takes it
    task automatic issue(logic [1:0] op, logic [3:0] x, logic [3:0] y, logic [7:0] v);
        int gap;
        if (run_left == 0)
        begin
            no_gaps  = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(10, 60);
        end
        run_left--;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        cmd         <= op;
        col_x       <= x;
        row_y       <= y;
        pixel_value <= v;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // Random pixel write; about half of the values turn the pixel off
    task automatic write_random_pixel();
        logic [7:0] v;
        v = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 255)) : 8'd0;
        issue(CMD_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), v);
    endtask

    // Any command code with random fields
    task automatic issue_noise();
        issue(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    // Idle tick or unused code with random fields; never starts a frame
    task automatic issue_idle_noise();
        logic [1:0] op;
        op = ($urandom_range(0, 1) == 1) ? 2'(CMD_TICK) : CMD_UNUSED;
        issue(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)));
    endtask

    // Tick the running frame to its end, mixing in commands that must be
    // rejected or ignored while it shifts
    task automatic finish_frame();
        while (pins.frame_active())
        begin
            if ($urandom_range(0, 11) == 0)
                issue_noise();
            else
                issue(CMD_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    // Drop start and wait until every queued pin state has been checked
    task automatic drain();
        start <= 1'b0;
        while (pins.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Write the enable level register; only called with the block drained
    task automatic write_enable_level(logic lvl);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        do @(posedge clk); while (!cfg_ready);
        pins.set_enable(lvl);
        @(negedge clk);
        cfg_valid <= 1'b0;
        repeat (2) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_TICK;
        col_x       = '0;
        row_y       = '0;
        pixel_value = '0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: high enable level, idle tick and unused code, corner
        // pixels and an overwrite
        write_enable_level(1'b1);
        issue(CMD_TICK,   4'd0,  4'd0,  8'd0);
        issue(CMD_UNUSED, 4'd15, 4'd15, 8'd255);
        issue(CMD_WRITE,  4'd0,  4'd0,  8'd255);
        issue(CMD_WRITE,  4'd15, 4'd15, 8'd1);
        issue(CMD_WRITE,  4'd15, 4'd0,  8'd128);
        issue(CMD_WRITE,  4'd0,  4'd15, 8'd0);
        issue(CMD_WRITE,  4'd7,  4'd3,  8'd1);
        issue(CMD_WRITE,  4'd8,  4'd3,  8'd2);
        issue(CMD_WRITE,  4'd1,  4'd0,  8'd1);
        issue(CMD_WRITE,  4'd1,  4'd0,  8'd0);

        // Random fill of the store mixed with idle ticks and unused codes
        repeat (130)
        begin
            if ($urandom_range(0, 7) == 0)
                issue_idle_noise();
            else
                write_random_pixel();
        end

        // One full frame with rejects and ignored codes along the way
        issue(CMD_START,  4'd0,  4'd0,  8'd0);
        issue(CMD_WRITE,  4'd5,  4'd5,  8'd255);
        issue(CMD_START,  4'd15, 4'd15, 8'd255);
        issue(CMD_UNUSED, 4'd0,  4'd0,  8'd0);
        issue(CMD_TICK,   4'd0,  4'd0,  8'd0);
        issue(CMD_TICK,   4'd0,  4'd0,  8'd0);
        issue(CMD_TICK,   4'd0,  4'd0,  8'd0);
        finish_frame();

        // Tail: random commands under a fresh enable level
        drain();
        write_enable_level(1'($urandom_range(0, 1)));
        repeat (30) issue_noise();

        // Wait for the last strobes, with a bound
        start  <= 1'b0;
        waited = 0;
        while (pins.pending() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pins.pending() != 0)
        begin
            $display("%0t: %0d queued results never arrived", $time, pins.pending());
            pins.errors += pins.pending();
        end

        $display("Covered %0d commands and %0d checked results over %0d full frames,",
                 pins.n_cmds, pins.n_checked, pins.n_frames);
        $display("with %0d rejected commands and %0d enable level writes.",
                 pins.n_rejects, pins.n_cfg);
        if (pins.errors == 0)
            $display("led_panel_remap_shift_driver_top_test passed");
        else
            $display("led_panel_remap_shift_driver_top_test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("%0t: run timed out", $time);
        $display("led_panel_remap_shift_driver_top_test failed");
        $finish;
    end

endmodule
